/* src/ffba_pkg.sv */
`timescale 1ns / 1ps
package ffba_pkg;

   localparam int MaxBlocksDef   = 64;
   localparam int HeaderBytesDef = 40;
   // index fields cover the largest table this block supports (1024 entries)
   localparam int IdxW           = 10;

   localparam logic [26:0] SizeMaxReq = 27'd100000000;

   localparam logic [1:0] FuncAlloc   = 2'd0;
   localparam logic [1:0] FuncFree    = 2'd1;
   localparam logic [1:0] FuncRealloc = 2'd2;

   localparam logic [1:0] StatOk       = 2'd0;
   localparam logic [1:0] StatBadSize  = 2'd1;
   localparam logic [1:0] StatNoSpace  = 2'd2;
   localparam logic [1:0] StatNotFound = 2'd3;

   localparam logic CsrHeapBase  = 1'b0;
   localparam logic CsrHeapLimit = 1'b1;

   // search token walking the cell chain
   typedef struct packed {
      logic            valid;
      logic            fit_found;
      logic [IdxW-1:0] fit_idx;
      logic [26:0]     fit_size;
      logic [31:0]     fit_addr;
      logic            match_found;
      logic [IdxW-1:0] match_idx;
      logic [26:0]     match_size;
   } token_type;

   // table update broadcast to all cells
   typedef struct packed {
      logic            use_en;
      logic [IdxW-1:0] use_idx;
      logic            free_en;
      logic [IdxW-1:0] free_idx;
      logic            new_en;
      logic [IdxW-1:0] new_idx;
      logic [26:0]     new_size;
      logic [31:0]     new_addr;
   } commit_type;

endpackage

/* src/ffba_if.sv */
`timescale 1ns / 1ps
interface ffba_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [26:0] req_size;
   logic [31:0] req_addr;
   modport source (output valid, output func, output req_size, output req_addr, input ready);
   modport sink   (input valid, input func, input req_size, input req_addr, output ready);
endinterface

interface ffba_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] result_addr;
   logic [6:0]  freed_blocks;
   logic [32:0] freed_bytes;
   logic [6:0]  total_blocks;
   logic [32:0] total_bytes;
   modport source (output valid, output status, output result_addr, output freed_blocks,
                   output freed_bytes, output total_blocks, output total_bytes, input ready);
   modport sink   (input valid, input status, input result_addr, input freed_blocks,
                   input freed_bytes, input total_blocks, input total_bytes, output ready);
endinterface

interface ffba_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/first_fit_block_allocator_core.sv */
`timescale 1ns / 1ps
// First-fit block allocator. One request (allocate, free, reallocate) is handled at a time:
// a search token walks a chain of MAX_BLOCKS cells, one cell per clock, each cell holding one
// table entry, and collects the first free block that fits and the used block whose address
// matches. Once the token has left the chain, and any earlier result has been read, the
// table is updated and the result loaded; the next request is taken as soon as the result is
// loaded, even if it has not yet been read, so a new request is never taken while one is being
// searched. No clearing pass after reset.
module first_fit_block_allocator_core #(
   parameter int MAX_BLOCKS   = ffba_pkg::MaxBlocksDef,
   parameter int HEADER_BYTES = ffba_pkg::HeaderBytesDef
) (
   input  logic           clock,
   input  logic           reset,
   ffba_req_if.sink       req_bus,
   ffba_rsp_if.source     rsp_bus,
   ffba_csr_if.sink       csr_bus
);

   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic                start_ff;
   logic [1:0]          func_ff;
   logic [26:0]         size_ff;
   logic [31:0]         addr_ff;
   ffba_pkg::token_type fin_tok_ff;
   logic [31:0]         heap_limit_ff;
   logic [32:0]         heap_top_ff, heap_top_in;
   logic [CNT_W-1:0]    blocks_used_ff, blocks_used_in;
   logic [CNT_W-1:0]    free_count_ff, free_count_in;
   logic [32:0]         free_sum_ff, free_sum_in;
   logic [32:0]         alloc_sum_ff, alloc_sum_in;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff, status_w;
   logic [31:0]         rsp_addr_ff, res_w;

   ffba_pkg::token_type  tok [0:MAX_BLOCKS];
   ffba_pkg::commit_type commit;

   logic        req_xfer, csr_xfer, fin_go;
   logic        size_bad, table_full, heap_over;
   logic [33:0] end_sum;
   logic [1:0]  a_status;
   logic [31:0] a_addr;
   logic        a_use, a_new;
   logic        do_alloc, free_match, use_fit, make_new;

   assign req_bus.ready = state_ff == ST_IDLE;
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_xfer      = csr_bus.valid;
   assign fin_go        = state_ff == ST_FIN && (!rsp_valid_ff || rsp_bus.ready);

   // ---------------- cell chain ----------------
   always_comb begin
      tok[0]       = '0;
      tok[0].valid = start_ff;
   end

   genvar gi;
   generate
      for (gi = 0; gi < MAX_BLOCKS; gi++) begin : g_cell
         ffba_cell #(.IDX(gi), .CNT_W(CNT_W)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .blocks_used (blocks_used_ff),
            .req_size    (size_ff),
            .req_addr    (addr_ff),
            .tok_in      (tok[gi]),
            .commit      (commit),
            .tok_out     (tok[gi+1])
         );
      end
   endgenerate

   // ---------------- decision ----------------
   always_comb begin
      size_bad   = size_ff == 27'd0 || size_ff > ffba_pkg::SizeMaxReq;
      table_full = blocks_used_ff >= CNT_W'(MAX_BLOCKS);
      end_sum    = {1'b0, heap_top_ff} + 34'(HEADER_BYTES) + 34'(size_ff);
      heap_over  = (end_sum - 34'd1) > {2'b00, heap_limit_ff};

      a_status = ffba_pkg::StatOk;
      a_addr   = '0;
      a_use    = 1'b0;
      a_new    = 1'b0;
      if (size_bad) begin
         a_status = ffba_pkg::StatBadSize;
      end else if (fin_tok_ff.fit_found) begin
         a_addr = fin_tok_ff.fit_addr;
         a_use  = 1'b1;
      end else if (table_full || heap_over) begin
         a_status = ffba_pkg::StatNoSpace;
      end else begin
         a_addr = 32'(heap_top_ff + 33'(HEADER_BYTES));
         a_new  = 1'b1;
      end

      status_w   = ffba_pkg::StatOk;
      res_w      = '0;
      do_alloc   = 1'b0;
      free_match = 1'b0;
      case (func_ff)
         ffba_pkg::FuncAlloc: begin
            do_alloc = 1'b1;
         end
         ffba_pkg::FuncFree: begin
            if (addr_ff != 32'd0) begin
               if (fin_tok_ff.match_found) free_match = 1'b1;
               else status_w = ffba_pkg::StatNotFound;
            end
         end
         ffba_pkg::FuncRealloc: begin
            if (addr_ff == 32'd0) begin
               do_alloc = 1'b1;
            end else if (!fin_tok_ff.match_found) begin
               status_w = ffba_pkg::StatNotFound;
            end else if (fin_tok_ff.match_size >= size_ff) begin
               res_w = addr_ff;
            end else begin
               do_alloc   = 1'b1;
               free_match = a_status == ffba_pkg::StatOk;
            end
         end
         default: begin
         end
      endcase

      use_fit  = do_alloc && a_use;
      make_new = do_alloc && a_new;
      if (do_alloc) begin
         status_w = a_status;
         res_w    = a_addr;
      end

      free_count_in  = free_count_ff - CNT_W'(use_fit) + CNT_W'(free_match);
      free_sum_in    = free_sum_ff - (use_fit ? 33'(fin_tok_ff.fit_size) : 33'd0)
                       + (free_match ? 33'(fin_tok_ff.match_size) : 33'd0);
      blocks_used_in = blocks_used_ff + CNT_W'(make_new);
      alloc_sum_in   = alloc_sum_ff + (make_new ? 33'(size_ff) : 33'd0);
      heap_top_in    = make_new ? end_sum[32:0] : heap_top_ff;

      commit.use_en   = fin_go && use_fit;
      commit.use_idx  = fin_tok_ff.fit_idx;
      commit.free_en  = fin_go && free_match;
      commit.free_idx = fin_tok_ff.match_idx;
      commit.new_en   = fin_go && make_new;
      commit.new_idx  = ffba_pkg::IdxW'(blocks_used_ff);
      commit.new_size = size_ff;
      commit.new_addr = a_addr;
   end

   // ---------------- control ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_xfer) state_in = ST_SCAN;
         ST_SCAN: if (tok[MAX_BLOCKS].valid) state_in = ST_FIN;
         ST_FIN:  if (fin_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         start_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         heap_limit_ff  <= '1;
         heap_top_ff    <= '0;
         blocks_used_ff <= '0;
         free_count_ff  <= '0;
         free_sum_ff    <= '0;
         alloc_sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         start_ff <= req_xfer;
         if (fin_go) begin
            rsp_valid_ff   <= 1'b1;
            heap_top_ff    <= heap_top_in;
            blocks_used_ff <= blocks_used_in;
            free_count_ff  <= free_count_in;
            free_sum_ff    <= free_sum_in;
            alloc_sum_ff   <= alloc_sum_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_xfer) begin
            if (csr_bus.index == ffba_pkg::CsrHeapBase) begin
               if (blocks_used_ff == '0) heap_top_ff <= {1'b0, csr_bus.data};
            end else if (csr_bus.index == ffba_pkg::CsrHeapLimit) begin
               heap_limit_ff <= csr_bus.data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         func_ff <= req_bus.func;
         size_ff <= req_bus.req_size;
         addr_ff <= req_bus.req_addr;
      end
      if (state_ff == ST_SCAN && tok[MAX_BLOCKS].valid) fin_tok_ff <= tok[MAX_BLOCKS];
      if (fin_go) begin
         rsp_status_ff <= status_w;
         rsp_addr_ff   <= res_w;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.result_addr  = rsp_addr_ff;
   assign rsp_bus.freed_blocks = 7'(free_count_ff);
   assign rsp_bus.freed_bytes  = free_sum_ff;
   assign rsp_bus.total_blocks = 7'(blocks_used_ff);
   assign rsp_bus.total_bytes  = alloc_sum_ff;

   // ---------------- checks ----------------
   a_free_le_used: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= blocks_used_ff)
      else $error("free block count exceeds created blocks");

   a_tok_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok[MAX_BLOCKS].valid |-> state_ff == ST_SCAN)
      else $error("search token left the chain outside a scan");

   a_xfer_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_SCAN && start_ff)
      else $error("request transfer did not start a scan");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result appeared without a finished scan");

endmodule

/* src/ffba_cell.sv */
`timescale 1ns / 1ps
module ffba_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CNT_W-1:0]       blocks_used,
   input  logic [26:0]            req_size,
   input  logic [31:0]            req_addr,
   input  ffba_pkg::token_type    tok_in,
   input  ffba_pkg::commit_type   commit,
   output ffba_pkg::token_type    tok_out
);

   localparam logic [ffba_pkg::IdxW-1:0] MyIdx = ffba_pkg::IdxW'(IDX);

   logic [26:0]         size_ff;
   logic [31:0]         addr_ff;
   logic                free_ff;
   logic                in_range;
   ffba_pkg::token_type tok_in_w;
   ffba_pkg::token_type tok_ff;

   assign in_range = CNT_W'(IDX) < blocks_used;

   always_comb begin
      tok_in_w = tok_in;
      if (tok_in.valid && in_range) begin
         if (!tok_in.fit_found && free_ff && size_ff >= req_size) begin
            tok_in_w.fit_found = 1'b1;
            tok_in_w.fit_idx   = MyIdx;
            tok_in_w.fit_size  = size_ff;
            tok_in_w.fit_addr  = addr_ff;
         end
         if (!tok_in.match_found && !free_ff && addr_ff == req_addr) begin
            tok_in_w.match_found = 1'b1;
            tok_in_w.match_idx   = MyIdx;
            tok_in_w.match_size  = size_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_w;
      end
   end

   always_ff @(posedge clock) begin
      if (commit.new_en && commit.new_idx == MyIdx) begin
         size_ff <= commit.new_size;
         addr_ff <= commit.new_addr;
         free_ff <= 1'b0;
      end else if (commit.use_en && commit.use_idx == MyIdx) begin
         free_ff <= 1'b0;
      end else if (commit.free_en && commit.free_idx == MyIdx) begin
         free_ff <= 1'b1;
      end
   end

   assign tok_out = tok_ff;

endmodule

/* tb/sv/first_fit_block_allocator_core_tb.sv */
`timescale 1ns / 1ps
module first_fit_block_allocator_core_tb;

   localparam int MaxBlk   = ffba_pkg::MaxBlocksDef;
   localparam int HdrBytes = ffba_pkg::HeaderBytesDef;
   localparam logic [1:0] FuncUnused = 2'd3;
   localparam logic [26:0] SizeAllOnes = 27'h7FF_FFFF;
   localparam int MaxPrinted = 50;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] result_addr;
      logic [6:0]  freed_blocks;
      logic [32:0] freed_bytes;
      logic [6:0]  total_blocks;
      logic [32:0] total_bytes;
   } alloc_result_type;

   class heap_tracker_type;
      logic [26:0]      blk_size [MaxBlk];
      logic [31:0]      blk_addr [MaxBlk];
      bit               blk_free [MaxBlk];
      int               n_blocks;
      int               n_free;
      logic [32:0]      top;
      logic [32:0]      free_total;
      logic [32:0]      alloc_total;
      logic [31:0]      base;
      logic [31:0]      limit;
      alloc_result_type pending [$];
      int               errors;

      function new();
         base        = '0;
         limit       = '1;
         top         = '0;
         n_blocks    = 0;
         n_free      = 0;
         free_total  = '0;
         alloc_total = '0;
         errors      = 0;
      endfunction

      function void write_reg(logic idx, logic [31:0] data);
         if (idx == ffba_pkg::CsrHeapBase) begin
            base = data;
            if (n_blocks == 0) top = {1'b0, data};
         end else begin
            limit = data;
         end
      endfunction

      function int find_used(logic [31:0] a);
         for (int i = 0; i < n_blocks; i++)
            if (blk_addr[i] == a && !blk_free[i]) return i;
         return -1;
      endfunction

      function void release_blk(int i);
         blk_free[i] = 1'b1;
         n_free++;
         free_total += 33'(blk_size[i]);
      endfunction

      // first fit over the table, else carve from the bump pointer
      function logic [1:0] grant(input logic [26:0] size, output logic [31:0] a);
         logic [33:0] fin;
         a = '0;
         if (size == 0 || size > ffba_pkg::SizeMaxReq) return ffba_pkg::StatBadSize;
         for (int i = 0; i < n_blocks; i++) begin
            if (blk_free[i] && blk_size[i] >= size) begin
               blk_free[i] = 1'b0;
               n_free--;
               free_total -= 33'(blk_size[i]);
               a = blk_addr[i];
               return ffba_pkg::StatOk;
            end
         end
         if (n_blocks >= MaxBlk) return ffba_pkg::StatNoSpace;
         fin = {1'b0, top} + 34'(HdrBytes) + 34'(size);
         if (fin - 34'd1 > {2'b00, limit}) return ffba_pkg::StatNoSpace;
         blk_size[n_blocks] = size;
         blk_addr[n_blocks] = top[31:0] + 32'(HdrBytes);
         blk_free[n_blocks] = 1'b0;
         a = blk_addr[n_blocks];
         n_blocks++;
         alloc_total += 33'(size);
         top = fin[32:0];
         return ffba_pkg::StatOk;
      endfunction

      function void note_request(logic [1:0] func, logic [26:0] size, logic [31:0] addr);
         alloc_result_type r;
         logic [1:0]       st;
         logic [31:0]      ga;
         int               i;
         st = ffba_pkg::StatOk;
         ga = '0;
         case (func)
            ffba_pkg::FuncAlloc: st = grant(size, ga);
            ffba_pkg::FuncFree: begin
               if (addr != 0) begin
                  i = find_used(addr);
                  if (i < 0) st = ffba_pkg::StatNotFound;
                  else release_blk(i);
               end
            end
            ffba_pkg::FuncRealloc: begin
               if (addr == 0) begin
                  st = grant(size, ga);
               end else begin
                  i = find_used(addr);
                  if (i < 0) begin
                     st = ffba_pkg::StatNotFound;
                  end else if (blk_size[i] >= size) begin
                     ga = addr;
                  end else begin
                     st = grant(size, ga);
                     if (st == ffba_pkg::StatOk) release_blk(i);
                  end
               end
            end
            default: ;
         endcase
         r.status       = st;
         r.result_addr  = ga;
         r.freed_blocks = 7'(n_free);
         r.freed_bytes  = free_total;
         r.total_blocks = 7'(n_blocks);
         r.total_bytes  = alloc_total;
         pending.push_back(r);
      endfunction

      // random payload address of a used (want_free 0) or free block, 0 if none
      function logic [31:0] pick(bit want_free);
         int hits;
         int k;
         hits = 0;
         for (int i = 0; i < n_blocks; i++)
            if (blk_free[i] == want_free) hits++;
         if (hits == 0) return '0;
         k = $urandom_range(hits - 1, 0);
         for (int i = 0; i < n_blocks; i++) begin
            if (blk_free[i] == want_free) begin
               if (k == 0) return blk_addr[i];
               k--;
            end
         end
         return '0;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MaxPrinted) $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task field(string name, logic [32:0] got, logic [32:0] want);
         if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
      endtask

      task check_response(alloc_result_type got);
         alloc_result_type want;
         if (pending.size() == 0) begin
            report($sformatf("result transfer with nothing pending, status %0d addr %h",
                             got.status, got.result_addr));
            return;
         end
         want = pending.pop_front();
         field("status", 33'(got.status), 33'(want.status));
         field("result_addr", 33'(got.result_addr), 33'(want.result_addr));
         field("freed_blocks", 33'(got.freed_blocks), 33'(want.freed_blocks));
         field("freed_bytes", got.freed_bytes, want.freed_bytes);
         field("total_blocks", 33'(got.total_blocks), 33'(want.total_blocks));
         field("total_bytes", got.total_bytes, want.total_bytes);
      endtask
   endclass

   logic clock;
   logic reset;
   bit   steady;
   int   stall_left;

   ffba_req_if req_bus();
   ffba_rsp_if rsp_bus();
   ffba_csr_if csr_bus();

   heap_tracker_type tracker = new();

   first_fit_block_allocator_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 3);
      if (r < 92) return $urandom_range(4, 12);
      return $urandom_range(20, 150);
   endfunction

   function automatic logic [26:0] rand_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 27'($urandom_range(1, 256));
      if (r < 75) return 27'($urandom_range(1, 65536));
      if (r < 85) return 27'($urandom_range(1, ffba_pkg::SizeMaxReq));
      if (r < 89) return '0;
      if (r < 94) return 27'($urandom_range(ffba_pkg::SizeMaxReq + 1, SizeAllOnes));
      if (r < 97) return ffba_pkg::SizeMaxReq;
      return SizeAllOnes;
   endfunction

   function automatic logic [31:0] pick_target();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return tracker.pick(1'b0);
      if (r < 85) return tracker.pick(1'b1);
      if (r < 92) return '0;
      return $urandom;
   endfunction

   // result side back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (!steady && $urandom_range(0, 99) < 25) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      alloc_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status       = rsp_bus.status;
         got.result_addr  = rsp_bus.result_addr;
         got.freed_blocks = rsp_bus.freed_blocks;
         got.freed_bytes  = rsp_bus.freed_bytes;
         got.total_blocks = rsp_bus.total_blocks;
         got.total_bytes  = rsp_bus.total_bytes;
         tracker.check_response(got);
      end
   end

   // valid is left high after the transfer; the next call lowers or reloads it
   task automatic send_request(logic [1:0] f, logic [26:0] s, logic [31:0] a);
      int gap;
      gap = (steady || $urandom_range(0, 99) < 50) ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid    = 1'b1;
      req_bus.func     = f;
      req_bus.req_size = s;
      req_bus.req_addr = a;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_request(f, s, a);
   endtask

   task automatic write_reg(logic idx, logic [31:0] d);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = d;
      do @(posedge clock); while (!csr_bus.ready);
      tracker.write_reg(idx, d);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic random_item();
      int          r;
      logic [1:0]  f;
      logic [26:0] s;
      logic [31:0] a;
      r = $urandom_range(0, 99);
      s = rand_size();
      a = $urandom;
      if (r < 40) begin
         f = ffba_pkg::FuncAlloc;
      end else if (r < 70) begin
         f = ffba_pkg::FuncFree;
         a = pick_target();
      end else if (r < 95) begin
         f = ffba_pkg::FuncRealloc;
         a = pick_target();
      end else begin
         f = FuncUnused;
      end
      send_request(f, s, a);
   endtask

   initial begin
      logic [31:0] b;
      logic [32:0] cap;
      reset            = 1'b1;
      steady           = 1'b0;
      req_bus.valid    = 1'b0;
      req_bus.func     = ffba_pkg::FuncAlloc;
      req_bus.req_size = '0;
      req_bus.req_addr = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = ffba_pkg::CsrHeapBase;
      csr_bus.data     = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // bump pointer parked at the top of the address space
      write_reg(ffba_pkg::CsrHeapBase, 32'hFFFF_FFFF);
      send_request(ffba_pkg::FuncAlloc, 27'd1, '0);
      send_request(ffba_pkg::FuncAlloc, '0, '0);
      send_request(ffba_pkg::FuncAlloc, SizeAllOnes, 32'hFFFF_FFFF);
      send_request(ffba_pkg::FuncAlloc, ffba_pkg::SizeMaxReq + 27'd1, '0);
      send_request(ffba_pkg::FuncFree, '0, '0);
      send_request(ffba_pkg::FuncFree, '0, 32'hFFFF_FFFF);
      send_request(ffba_pkg::FuncRealloc, 27'd5, 32'h1234_5678);
      send_request(FuncUnused, SizeAllOnes, 32'hFFFF_FFFF);
      send_request(ffba_pkg::FuncRealloc, '0, '0);
      drain();

      write_reg(ffba_pkg::CsrHeapLimit, '0);
      write_reg(ffba_pkg::CsrHeapBase, '0);
      send_request(ffba_pkg::FuncAlloc, 27'd1, '0);
      drain();

      // heap sized for exactly one 100 byte block
      b = 32'($urandom_range(1, 32'h00FF_FFFF)) << 4;
      write_reg(ffba_pkg::CsrHeapBase, b);
      write_reg(ffba_pkg::CsrHeapLimit, b + 32'd139);
      send_request(ffba_pkg::FuncAlloc, 27'd100, '0);
      send_request(ffba_pkg::FuncAlloc, 27'd1, '0);
      send_request(ffba_pkg::FuncRealloc, '0, b + 32'd40);
      send_request(ffba_pkg::FuncRealloc, 27'd100, b + 32'd40);
      send_request(ffba_pkg::FuncRealloc, 27'd101, b + 32'd40);
      send_request(ffba_pkg::FuncFree, '0, b + 32'd40);
      send_request(ffba_pkg::FuncFree, '0, b + 32'd40);
      send_request(ffba_pkg::FuncRealloc, 27'd5, b + 32'd40);
      send_request(ffba_pkg::FuncAlloc, ffba_pkg::SizeMaxReq, '0);
      send_request(ffba_pkg::FuncAlloc, 27'd60, '0);
      drain();

      write_reg(ffba_pkg::CsrHeapLimit, 32'hFFFF_FFFF);
      write_reg(ffba_pkg::CsrHeapBase, '0);
      send_request(ffba_pkg::FuncRealloc, 27'd200, b + 32'd40);
      send_request(ffba_pkg::FuncAlloc, ffba_pkg::SizeMaxReq, '0);
      send_request(ffba_pkg::FuncRealloc, 27'd7, '0);
      send_request(ffba_pkg::FuncFree, '0, b + 32'd180);
      send_request(FuncUnused, '0, '0);

      for (int p = 0; p < 5; p++) begin
         drain();
         write_reg(ffba_pkg::CsrHeapBase, $urandom);
         case (p)
            1: begin
               cap = tracker.top + 33'($urandom_range(0, 4000));
               write_reg(ffba_pkg::CsrHeapLimit,
                         cap > 33'h0_FFFF_FFFF ? 32'hFFFF_FFFF : cap[31:0]);
            end
            3: write_reg(ffba_pkg::CsrHeapLimit, '0);
            default: write_reg(ffba_pkg::CsrHeapLimit, 32'hFFFF_FFFF);
         endcase
         steady = (p == 2);
         repeat (290) random_item();
      end
      drain();
      steady = 1'b0;
      repeat (MaxBlk + 3 + 20) @(posedge clock);

      if (tracker.errors == 0 && tracker.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* sim.f */
src/ffba_pkg.sv
src/ffba_if.sv
src/ffba_cell.sv
src/first_fit_block_allocator_core.sv
tb/sv/first_fit_block_allocator_core_tb.sv
